### rtl/aesctr_pkg.sv
// Package for the AES-CTR byte stream cipher: types, constants and
// the S-box, round-constant and column-mix helpers. No dependencies.
package aesctr_pkg;

	localparam int unsigned AddrW = 6;
	localparam int unsigned KsDepth = 60;
	localparam int unsigned KsAddrW = 6;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_KSIZE = 3'd4;
	localparam logic [2:0] REG_IV = 3'd5;
	localparam logic [2:0] REG_ENABLE = 3'd6;

	localparam logic [3:0] ROUNDS_128 = 4'd10;
	localparam logic [3:0] ROUNDS_256 = 4'd14;
	localparam logic [4:0] POS_EMPTY = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_CHECK,
		ST_ENC,
		ST_OUT
	} state_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		case (idx)
			4'd1: rcon = 8'h01;
			4'd2: rcon = 8'h02;
			4'd3: rcon = 8'h04;
			4'd4: rcon = 8'h08;
			4'd5: rcon = 8'h10;
			4'd6: rcon = 8'h20;
			4'd7: rcon = 8'h40;
			4'd8: rcon = 8'h80;
			4'd9: rcon = 8'h1b;
			4'd10: rcon = 8'h36;
			default: rcon = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] p);
		logic [7:0] a0, a1, a2, a3, t;
		a0 = p[31:24];
		a1 = p[23:16];
		a2 = p[15:8];
		a3 = p[7:0];
		t = a0 ^ a1 ^ a2 ^ a3;
		mix_col = {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
			a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
	endfunction

endpackage

### rtl/aesctr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aesctr_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/aesctr_round.sv
// AES round transform: SubBytes, ShiftRows and optional MixColumns.
// Depends on aesctr_pkg.
module aesctr_round (
	input  logic [127:0] state_in,
	input  logic         do_mix,
	output logic [127:0] state_out
);
	logic [7:0] o [16];
	logic [7:0] s [16];
	logic [31:0] col;

	always_comb begin
		for (int b = 0; b < 16; b++) begin
			o[b] = aesctr_pkg::SBOX[state_in[127-8*b -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				s[4*c+r] = o[4*((c+r)%4)+r];
			end
		end
		state_out = '0;
		for (int c = 0; c < 4; c++) begin
			col = {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]};
			state_out[127-32*c -: 32] = do_mix ? aesctr_pkg::mix_col(col) : col;
		end
	end
endmodule

### rtl/aes_ctr_byte_stream_cipher.sv
// Top level of the AES-CTR byte stream cipher: APB register file,
// sequencer, key expansion and keystream generation.
// Depends on aesctr_pkg, aesctr_ram and aesctr_round.
//
// Usage: bytes enter on the in_* valid/ready channel with data_in,
// restart and frame_end, and leave on the out_* channel with data_out
// and frame_end_out, one result beat per input beat, in order.
// Registers are written through the APB port (8-byte stride); the user
// must write them only while idle, which the block does not enforce.
// A restart beat with cipher_enable set expands the key into a 60-word
// schedule RAM, one word per cycle (44 words for AES-128, 60 for
// AES-256), and loads the counter from initial_vector.
// A byte with keystream left goes from idle through ST_CHECK to ST_OUT,
// where the result register is loaded once it is free. When 16 bytes
// are used up, one block is encrypted by a shared round unit in
// ST_ENC: in each round, including the initial key addition, phase 0
// applies the round transform (not in round 0) and phases 1 to 4 add
// one key column each (one RAM read per key column). One byte is in
// work at a time. A stalled receiver holds the result register; the
// next byte is still taken and worked on, then waits until that
// register is emptied. Reset clears registers, counter and position;
// bytes pass unchanged until a restart with cipher_enable set is taken.
module aes_ctr_byte_stream_cipher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aesctr_pkg::AddrW-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_in,
	input  logic                        restart,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  data_out,
	output logic                        frame_end_out
);
	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic        ksize_q, enable_q;
	logic [31:0] iv_q;

	aesctr_pkg::state_t state_q, state_d;

	logic [7:0]   byte_q;
	logic         fend_q;
	logic         key256_q;
	logic [3:0]   rounds_q;
	logic [127:0] ctr_q, ks_q, st_q;
	logic [4:0]   pos_q;
	logic         armed_q;
	logic [5:0]   widx_q;
	logic [31:0]  win_q [8];
	logic [3:0]   rnd_q;
	logic [2:0]   ph_q;
	logic         out_valid_q;
	logic [7:0]   data_out_q;
	logic         fend_out_q;

	logic         cfg_we, in_beat, out_beat, out_free;
	logic [2:0]   cfg_idx;
	logic [5:0]   wtotal;
	logic [31:0]  wnew, wk, wt, wload;
	logic [2:0]   wmod;
	logic [3:0]   ridx;
	logic         kram_we;
	logic [5:0]   kram_raddr;
	logic [31:0]  kram_rdata;
	logic [127:0] round_out, st_xor;
	logic [6:0]   ks_bit;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];
	assign in_ready = (state_q == aesctr_pkg::ST_IDLE);
	assign in_beat = in_valid && in_ready;
	assign out_beat = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign data_out = data_out_q;
	assign frame_end_out = fend_out_q;

	always_comb begin
		case (cfg_idx)
			aesctr_pkg::REG_KEY0: prdata = key0_q;
			aesctr_pkg::REG_KEY1: prdata = key1_q;
			aesctr_pkg::REG_KEY2: prdata = key2_q;
			aesctr_pkg::REG_KEY3: prdata = key3_q;
			aesctr_pkg::REG_KSIZE: prdata = {63'd0, ksize_q};
			aesctr_pkg::REG_IV: prdata = {32'd0, iv_q};
			aesctr_pkg::REG_ENABLE: prdata = {63'd0, enable_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			ksize_q <= 1'b0;
			iv_q <= '0;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				aesctr_pkg::REG_KEY0: key0_q <= pwdata;
				aesctr_pkg::REG_KEY1: key1_q <= pwdata;
				aesctr_pkg::REG_KEY2: key2_q <= pwdata;
				aesctr_pkg::REG_KEY3: key3_q <= pwdata;
				aesctr_pkg::REG_KSIZE: ksize_q <= pwdata[0];
				aesctr_pkg::REG_IV: iv_q <= pwdata[31:0];
				aesctr_pkg::REG_ENABLE: enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// key expansion, one word per cycle from an 8-word window
	assign wtotal = key256_q ? 6'd59 : 6'd43;
	assign wmod = key256_q ? widx_q[2:0] : {1'b0, widx_q[1:0]};
	assign ridx = key256_q ? {1'b0, widx_q[5:3]} : widx_q[5:2];
	assign wk = key256_q ? win_q[0] : win_q[4];

	always_comb begin
		case (widx_q[2:0])
			3'd0: wload = key0_q[63:32];
			3'd1: wload = key0_q[31:0];
			3'd2: wload = key1_q[63:32];
			3'd3: wload = key1_q[31:0];
			3'd4: wload = key2_q[63:32];
			3'd5: wload = key2_q[31:0];
			3'd6: wload = key3_q[63:32];
			default: wload = key3_q[31:0];
		endcase
		if (wmod == 3'd0) begin
			wt = aesctr_pkg::sub_word({win_q[7][23:0], win_q[7][31:24]})
				^ {aesctr_pkg::rcon(ridx), 24'd0};
		end else if (key256_q && wmod == 3'd4) begin
			wt = aesctr_pkg::sub_word(win_q[7]);
		end else begin
			wt = win_q[7];
		end
		if (widx_q < (key256_q ? 6'd8 : 6'd4)) begin
			wnew = wload;
		end else begin
			wnew = wk ^ wt;
		end
	end

	assign kram_we = (state_q == aesctr_pkg::ST_KEY);
	assign kram_raddr = {rnd_q, ph_q[1:0]};

	aesctr_ram #(
		.Width(32),
		.Depth(aesctr_pkg::KsDepth)
	) u_kram (
		.clk  (clk),
		.we   (kram_we),
		.waddr(widx_q),
		.wdata(wnew),
		.raddr(kram_raddr),
		.rdata(kram_rdata)
	);

	aesctr_round u_round (
		.state_in (st_q),
		.do_mix   (rnd_q != rounds_q),
		.state_out(round_out)
	);

	always_comb begin
		st_xor = st_q;
		case (ph_q)
			3'd1: st_xor[127:96] = st_q[127:96] ^ kram_rdata;
			3'd2: st_xor[95:64] = st_q[95:64] ^ kram_rdata;
			3'd3: st_xor[63:32] = st_q[63:32] ^ kram_rdata;
			3'd4: st_xor[31:0] = st_q[31:0] ^ kram_rdata;
			default: st_xor = st_q;
		endcase
	end

	assign ks_bit = {3'd0, 4'd15 - pos_q[3:0]} << 3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesctr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aesctr_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = (restart && enable_q) ? aesctr_pkg::ST_KEY
						: aesctr_pkg::ST_CHECK;
				end
			end
			aesctr_pkg::ST_KEY: begin
				if (widx_q == wtotal) begin
					state_d = aesctr_pkg::ST_CHECK;
				end
			end
			aesctr_pkg::ST_CHECK: begin
				state_d = (armed_q && pos_q[4]) ? aesctr_pkg::ST_ENC : aesctr_pkg::ST_OUT;
			end
			aesctr_pkg::ST_ENC: begin
				if (ph_q == 3'd4 && rnd_q == rounds_q) begin
					state_d = aesctr_pkg::ST_OUT;
				end
			end
			aesctr_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = aesctr_pkg::ST_IDLE;
				end
			end
			default: state_d = aesctr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key256_q <= 1'b0;
			rounds_q <= aesctr_pkg::ROUNDS_128;
			ctr_q <= '0;
			pos_q <= aesctr_pkg::POS_EMPTY;
			armed_q <= 1'b0;
			widx_q <= '0;
			rnd_q <= '0;
			ph_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == aesctr_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				aesctr_pkg::ST_IDLE: begin
					if (in_beat && restart && enable_q) begin
						key256_q <= ksize_q;
						rounds_q <= ksize_q ? aesctr_pkg::ROUNDS_256 : aesctr_pkg::ROUNDS_128;
						ctr_q <= {iv_q, 96'd0};
						pos_q <= aesctr_pkg::POS_EMPTY;
						armed_q <= 1'b1;
						widx_q <= '0;
					end
				end
				aesctr_pkg::ST_KEY: begin
					widx_q <= widx_q + 6'd1;
				end
				aesctr_pkg::ST_CHECK: begin
					rnd_q <= '0;
					ph_q <= '0;
				end
				aesctr_pkg::ST_ENC: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == rounds_q) begin
							pos_q <= '0;
							ctr_q <= ctr_q + 128'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				aesctr_pkg::ST_OUT: begin
					if (out_free && armed_q) begin
						pos_q <= pos_q + 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_q <= data_in;
			fend_q <= frame_end;
		end
		if (state_q == aesctr_pkg::ST_KEY) begin
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[7] <= wnew;
		end
		if (state_q == aesctr_pkg::ST_CHECK) begin
			st_q <= ctr_q;
		end
		if (state_q == aesctr_pkg::ST_ENC) begin
			if (ph_q == 3'd0) begin
				if (rnd_q != 4'd0) begin
					st_q <= round_out;
				end
			end else begin
				st_q <= st_xor;
				if (ph_q == 3'd4 && rnd_q == rounds_q) begin
					ks_q <= st_xor;
				end
			end
		end
		if (state_q == aesctr_pkg::ST_OUT && out_free) begin
			data_out_q <= armed_q ? (byte_q ^ ks_q[ks_bit +: 8]) : byte_q;
			fend_out_q <= fend_q;
		end
	end
endmodule

### rtl/aesctr_checker.sv
// Port-level checker for the AES-CTR byte stream cipher, bound to the top.
// Depends on aes_ctr_byte_stream_cipher.
module aesctr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out,
	input logic       frame_end_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_out) && $stable(frame_end_out))
		else $error("result beat changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("busy window broken after input beat");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");
endmodule

bind aes_ctr_byte_stream_cipher aesctr_checker u_aesctr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.data_out     (data_out),
	.frame_end_out(frame_end_out)
);
